[hdl/isfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Shared types and constants for the byte-serial sensor frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

    localparam int          PAYLOAD_LEN   = 8;
    localparam int          COUNT_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int          INDEX_W       = $clog2(PAYLOAD_LEN);

    localparam logic [7:0]  HEADER_RESET  = 8'h55;
    localparam logic [7:0]  TYPE_FIRST    = 8'h50;
    localparam logic [7:0]  TYPE_LAST     = 8'h58;

    localparam logic [3:0]  KIND_TIME     = 4'd0;
    localparam logic [3:0]  KIND_PORT     = 4'd5;
    localparam logic [3:0]  KIND_HEIGHT   = 4'd6;
    localparam logic [3:0]  KIND_LATLON   = 4'd7;
    localparam logic [3:0]  KIND_SPEED    = 4'd8;

    localparam logic [11:0] YEAR_BASE     = 12'd2000;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TYPE = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    typedef struct packed {
        logic        [3:0]  frame_kind;
        logic signed [15:0] word0;
        logic signed [15:0] word1;
        logic signed [15:0] word2;
        logic signed [15:0] word3;
        logic signed [31:0] long_low;
        logic signed [31:0] long_high;
        logic        [11:0] year;
    } result_t;

endpackage

[hdl/isfp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser state machine
// Tracks the frame position, keeps the checksum and payload bytes, and builds
// the decoded result on the checksum byte.
// ----------------------------------------------------------------------------
module isfp_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_accept,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             header_byte,
    output logic                   at_checksum,
    output logic                   result_valid,
    output isfp_pkg::result_t      result
);

    isfp_pkg::mode_t                  mode_reg, mode_next;
    logic [3:0]                       kind_reg, kind_next;
    logic [isfp_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [7:0]                       sum_reg, sum_next;
    logic [7:0]                       payload_reg [isfp_pkg::PAYLOAD_LEN];
    logic                             payload_we;
    logic                             type_ok;
    logic                             last_pos;
    logic                             wide;

    assign type_ok  = (rx_byte >= isfp_pkg::TYPE_FIRST) && (rx_byte <= isfp_pkg::TYPE_LAST);
    assign last_pos = (count_reg == isfp_pkg::COUNT_W'(isfp_pkg::PAYLOAD_LEN));
    assign at_checksum = (mode_reg == isfp_pkg::MODE_DATA) && last_pos;

    // Next state.
    always_comb begin
        mode_next = mode_reg;
        if (byte_accept) begin
            case (mode_reg)
                isfp_pkg::MODE_IDLE: begin
                    mode_next = (rx_byte == header_byte) ? isfp_pkg::MODE_TYPE
                                                         : isfp_pkg::MODE_IDLE;
                end
                isfp_pkg::MODE_TYPE: begin
                    mode_next = type_ok ? isfp_pkg::MODE_DATA : isfp_pkg::MODE_IDLE;
                end
                isfp_pkg::MODE_DATA: begin
                    mode_next = last_pos ? isfp_pkg::MODE_IDLE : isfp_pkg::MODE_DATA;
                end
                default: begin
                    // The unused code behaves exactly as idle.
                    mode_next = (rx_byte == header_byte) ? isfp_pkg::MODE_TYPE
                                                         : isfp_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Datapath updates for each state.
    always_comb begin
        kind_next    = kind_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        payload_we   = 1'b0;
        result_valid = 1'b0;
        if (byte_accept) begin
            case (mode_reg)
                isfp_pkg::MODE_TYPE: begin
                    if (type_ok) begin
                        kind_next  = rx_byte[3:0];
                        sum_next   = sum_reg + rx_byte;
                        count_next = '0;
                    end
                end
                isfp_pkg::MODE_DATA: begin
                    if (!last_pos) begin
                        payload_we = 1'b1;
                        sum_next   = sum_reg + rx_byte;
                        count_next = count_reg + 1'b1;
                    end else begin
                        result_valid = (sum_reg == rx_byte)
                                    && (kind_reg != isfp_pkg::KIND_PORT)
                                    && (kind_reg != isfp_pkg::KIND_HEIGHT);
                        count_next   = '0;
                        sum_next     = header_byte;
                    end
                end
                default: begin
                    // Idle, and the unused code, which behaves as idle.
                    if (rx_byte == header_byte) begin
                        sum_next = header_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= isfp_pkg::MODE_IDLE;
            kind_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= isfp_pkg::HEADER_RESET;
        end else begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (payload_we) begin
            payload_reg[count_reg[isfp_pkg::INDEX_W-1:0]] <= rx_byte;
        end
    end

    assign wide = (kind_reg == isfp_pkg::KIND_LATLON) || (kind_reg == isfp_pkg::KIND_SPEED);

    always_comb begin
        result.frame_kind = kind_reg;
        result.word0      = {payload_reg[1], payload_reg[0]};
        result.word1      = {payload_reg[3], payload_reg[2]};
        result.word2      = {payload_reg[5], payload_reg[4]};
        result.word3      = {payload_reg[7], payload_reg[6]};
        result.long_low   = wide ? {payload_reg[3], payload_reg[2],
                                    payload_reg[1], payload_reg[0]} : 32'sd0;
        result.long_high  = wide ? {payload_reg[7], payload_reg[6],
                                    payload_reg[5], payload_reg[4]} : 32'sd0;
        result.year       = (kind_reg == isfp_pkg::KIND_TIME)
                          ? (12'(payload_reg[0]) + isfp_pkg::YEAR_BASE) : 12'd0;
    end

endmodule

[hdl/imu_serial_frame_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser, top level
// Parses the byte stream of an inertial sensor serial link into decoded frames.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ---------------------------------
//  s_        in         s_valid / s_ready    s_rx_byte
//  m_        out        m_valid / m_ready    m_frame_kind, m_word0..m_word3,
//                                            m_long_low, m_long_high, m_year
//  cfg_      in         cfg_we (no wait)     cfg_wdata (header byte)
//
// One byte is taken per cycle while s_ready is high; the parser state and, for a
// finished frame, the output register load at the end of the transfer cycle.
// Reset is synchronous and active low; it clears the parser state, the output
// valid flag and sets the header byte back to 0x55.
// A pending result does not stall the byte stream: s_ready only drops when the
// next byte is a checksum byte and the previous result has not been taken yet.
// Since a frame is eleven bytes long, this only happens after a long stall.
//
module imu_serial_frame_parser_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_frame_kind,
    output logic signed [15:0] m_word0,
    output logic signed [15:0] m_word1,
    output logic signed [15:0] m_word2,
    output logic signed [15:0] m_word3,
    output logic signed [31:0] m_long_low,
    output logic signed [31:0] m_long_high,
    output logic [11:0]        m_year
);

    logic [7:0]         header_reg;
    logic               m_valid_reg, m_valid_next;
    isfp_pkg::result_t  result_reg;
    isfp_pkg::result_t  result;
    logic               result_valid;
    logic               at_checksum;
    logic               byte_accept;

    // The user must write the header byte register only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= isfp_pkg::HEADER_RESET;
        end else if (cfg_we) begin
            header_reg <= cfg_wdata;
        end
    end

    // Hold off only the checksum byte while the output register is still full.
    assign s_ready     = !(at_checksum && m_valid_reg && !m_ready);
    assign byte_accept = s_valid && s_ready;

    isfp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_rx_byte),
        .header_byte  (header_reg),
        .at_checksum  (at_checksum),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output register. A new result can only arrive when the register is empty
    // or being drained, which the s_ready term above guarantees.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (result_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            result_reg <= result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_kind = result_reg.frame_kind;
    assign m_word0      = result_reg.word0;
    assign m_word1      = result_reg.word1;
    assign m_word2      = result_reg.word2;
    assign m_word3      = result_reg.word3;
    assign m_long_low   = result_reg.long_low;
    assign m_long_high  = result_reg.long_high;
    assign m_year       = result_reg.year;

endmodule

[hdl/isfp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser checker
// Port-level assertions for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module isfp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [3:0]         m_frame_kind,
    input logic signed [31:0] m_long_low,
    input logic signed [31:0] m_long_high,
    input logic [11:0]        m_year
);

    // A result that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // Port and height frames never produce a result, and no code above speed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_kind != isfp_pkg::KIND_PORT)
                 && (m_frame_kind != isfp_pkg::KIND_HEIGHT)
                 && (m_frame_kind <= isfp_pkg::KIND_SPEED))
        else $error("unexpected frame kind on result");

    // The 32-bit words are zero outside position and speed frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_kind != isfp_pkg::KIND_LATLON)
                && (m_frame_kind != isfp_pkg::KIND_SPEED)
        |-> (m_long_low == 32'sd0) && (m_long_high == 32'sd0))
        else $error("long words set on a short frame");

    // The year is in range for time frames and zero otherwise.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_frame_kind == isfp_pkg::KIND_TIME)
                     ? (m_year >= isfp_pkg::YEAR_BASE) : (m_year == 12'd0)))
        else $error("year field inconsistent with frame kind");

endmodule

bind imu_serial_frame_parser_top isfp_checker u_isfp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_kind (m_frame_kind),
    .m_long_low   (m_long_low),
    .m_long_high  (m_long_high),
    .m_year       (m_year)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IMU serial frame parser
// Streams sensor frames, broken frames and line noise into the parser under
// random flow control, predicts every decoded frame and checks each one.
// ----------------------------------------------------------------------------
module tb;

    // The slowest correct run stays far below this. The counter is only a guard
    // against a hung handshake.
    localparam int CYCLE_LIMIT  = 400000;
    // Frame bytes per random phase, four random phases in total.
    localparam int PHASE_BYTES  = 370;
    // Cycles to let pass after the last expected frame, so that a frame that
    // ends without a result is out of the parser before a register write.
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] value;
        bit         hold;   // wait for every pending frame before this transfer
    } byte_item_t;

    // Clock, reset and every block input start at a known value.
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = 8'h00;
    logic               s_valid   = 1'b0;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_ready   = 1'b0;

    logic               s_ready;
    logic               m_valid;
    logic [3:0]         m_frame_kind;
    logic signed [15:0] m_word0;
    logic signed [15:0] m_word1;
    logic signed [15:0] m_word2;
    logic signed [15:0] m_word3;
    logic signed [31:0] m_long_low;
    logic signed [31:0] m_long_high;
    logic [11:0]        m_year;

    // Bytes waiting for the driver, and frames waiting for the monitor.
    byte_item_t          byte_queue[$];
    isfp_pkg::result_t   pending_frames[$];

    // Our own copy of the parser state and of the header register.
    logic [7:0]      header_reg = isfp_pkg::HEADER_RESET;
    isfp_pkg::mode_t parse_state = isfp_pkg::MODE_IDLE;
    logic [3:0]      kind_reg = 4'd0;
    int              count_reg = 0;
    logic [7:0]      sum_reg = isfp_pkg::HEADER_RESET;
    logic [7:0]      payload_mem [isfp_pkg::PAYLOAD_LEN];

    int error_count  = 0;
    int cycle_count  = 0;
    int bytes_sent   = 0;
    int frames_seen  = 0;
    int header_writes = 0;

    imu_serial_frame_parser_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_kind (m_frame_kind),
        .m_word0      (m_word0),
        .m_word1      (m_word1),
        .m_word2      (m_word2),
        .m_word3      (m_word3),
        .m_long_low   (m_long_low),
        .m_long_high  (m_long_high),
        .m_year       (m_year)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Frame decoder. It is called once for every byte that the parser takes and
    // queues the frame that the byte completes, if it completes one.
    // ------------------------------------------------------------------------
    function automatic void decode_byte(input logic [7:0] b);
        isfp_pkg::result_t r;
        logic              wide;
        case (parse_state)
            isfp_pkg::MODE_TYPE: begin
                if (b >= isfp_pkg::TYPE_FIRST && b <= isfp_pkg::TYPE_LAST) begin
                    kind_reg    = 4'(b - isfp_pkg::TYPE_FIRST);
                    sum_reg     = sum_reg + b;
                    count_reg   = 0;
                    parse_state = isfp_pkg::MODE_DATA;
                end else begin
                    // A bad type byte is dropped; it never starts a new frame.
                    parse_state = isfp_pkg::MODE_IDLE;
                end
            end
            isfp_pkg::MODE_DATA: begin
                if (count_reg < isfp_pkg::PAYLOAD_LEN) begin
                    payload_mem[count_reg] = b;
                    sum_reg   = sum_reg + b;
                    count_reg = count_reg + 1;
                end else begin
                    // This is the checksum byte. Port and height frames are
                    // checked like the others but never produce a result.
                    if (sum_reg == b && kind_reg != isfp_pkg::KIND_PORT &&
                        kind_reg != isfp_pkg::KIND_HEIGHT) begin
                        wide         = (kind_reg == isfp_pkg::KIND_LATLON ||
                                        kind_reg == isfp_pkg::KIND_SPEED);
                        r.frame_kind = kind_reg;
                        r.word0      = {payload_mem[1], payload_mem[0]};
                        r.word1      = {payload_mem[3], payload_mem[2]};
                        r.word2      = {payload_mem[5], payload_mem[4]};
                        r.word3      = {payload_mem[7], payload_mem[6]};
                        r.long_low   = wide ? {payload_mem[3], payload_mem[2],
                                               payload_mem[1], payload_mem[0]} : 32'd0;
                        r.long_high  = wide ? {payload_mem[7], payload_mem[6],
                                               payload_mem[5], payload_mem[4]} : 32'd0;
                        r.year       = (kind_reg == isfp_pkg::KIND_TIME) ?
                                       isfp_pkg::YEAR_BASE + {4'd0, payload_mem[0]} : 12'd0;
                        pending_frames.push_back(r);
                    end
                    count_reg   = 0;
                    sum_reg     = header_reg;
                    parse_state = isfp_pkg::MODE_IDLE;
                end
            end
            default: begin
                // Idle: only the current header byte starts a frame, and it
                // seeds the checksum with the header value in force now.
                parse_state = isfp_pkg::MODE_IDLE;
                if (b == header_reg) begin
                    sum_reg     = header_reg;
                    parse_state = isfp_pkg::MODE_TYPE;
                end
            end
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s: expected %h, got %h", name, want, got));
    endtask

    task automatic queue_byte(input logic [7:0] value, input bit hold);
        byte_item_t item;
        item.value = value;
        item.hold  = hold;
        byte_queue.push_back(item);
    endtask

    // Queues header, type, eight payload bytes and a checksum built from the
    // header in force. A corrupt frame gets a checksum that is XORed with a random
    // nonzero mask, so that it never matches.
    task automatic queue_frame(input logic [7:0] type_code, input logic [7:0] payload [8],
                               input bit corrupt, input bit hold);
        logic [7:0] sum;
        sum = header_reg + type_code;
        queue_byte(header_reg, hold);
        queue_byte(type_code, 1'b0);
        for (int i = 0; i < 8; i++) begin
            sum = sum + payload[i];
            queue_byte(payload[i], 1'b0);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        queue_byte(sum, 1'b0);
    endtask

    // Waits until the parser has nothing in flight, then writes the header
    // register. The written value becomes the decoder's header at once, since
    // no byte is transferred around the write.
    task automatic write_header(input logic [7:0] value);
        while (byte_queue.size() != 0 || s_valid || pending_frames.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        header_reg = value;
        header_writes++;
    endtask

    // One phase of random traffic. Most of it is well-formed frames with random
    // content, some of them carrying the header byte as data; the rest is
    // frames with a bad checksum, bad type bytes and stray bytes between frames.
    task automatic run_random_phase();
        logic [7:0] payload [8];
        logic [7:0] b;
        int         phase_bytes;
        int         frame_no;
        int         pick;
        phase_bytes = 0;
        frame_no    = 0;
        while (phase_bytes < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                for (int i = 0; i < 8; i++) begin
                    case ($urandom_range(0, 15))
                        0:       payload[i] = header_reg;
                        1:       payload[i] = 8'h00;
                        2:       payload[i] = 8'hFF;
                        3:       payload[i] = 8'h80;
                        4:       payload[i] = 8'h7F;
                        default: payload[i] = 8'($urandom_range(0, 255));
                    endcase
                end
                // Once per phase the sender holds off until the output side
                // has delivered every frame it owes.
                queue_frame(8'($urandom_range(isfp_pkg::TYPE_FIRST, isfp_pkg::TYPE_LAST)),
                            payload, pick >= 72, frame_no == 10);
                frame_no++;
                phase_bytes += 11;
            end else if (pick < 92) begin
                b = 8'($urandom_range(0, 255));
                while (b >= isfp_pkg::TYPE_FIRST && b <= isfp_pkg::TYPE_LAST)
                    b = 8'($urandom_range(0, 255));
                if ((header_reg < isfp_pkg::TYPE_FIRST || header_reg > isfp_pkg::TYPE_LAST) &&
                    $urandom_range(0, 3) == 0)
                    b = header_reg;
                queue_byte(header_reg, 1'b0);
                queue_byte(b, 1'b0);
                phase_bytes += 2;
            end else begin
                // Stray bytes in idle are ignored and do not count.
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == header_reg)
                        b = b ^ 8'h01;
                    queue_byte(b, 1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. It predicts from each transfer that happened at this edge, then
    // offers the next byte in bursts of random length with random gaps.
    // ------------------------------------------------------------------------
    int         gap_left   = 0;
    int         burst_left = 1;
    byte_item_t next_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_rx_byte  <= 8'h00;
            gap_left   = 0;
            burst_left = $urandom_range(1, 24);
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_rx_byte);
                bytes_sent++;
            end
            // A byte on offer stays put until its transfer.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0 &&
                             !(byte_queue[0].hold && pending_frames.size() != 0)) begin
                    next_item = byte_queue.pop_front();
                    s_valid   <= 1'b1;
                    s_rx_byte <= next_item.value;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // About one burst in four runs straight into the next.
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern. The share of stalled cycles is picked anew for each
    // pattern of random length, from never up to nearly always, so that long stalls
    // also push back on the checksum byte of the next frame.
    // ------------------------------------------------------------------------
    int stall_pct    = 0;
    int pattern_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            pattern_left = 0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 95;
                endcase
                pattern_left = $urandom_range(50, 300);
            end
            pattern_left--;
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result transfer is matched against the oldest frame that
    // the decoder has queued.
    // ------------------------------------------------------------------------
    isfp_pkg::result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                flag_error($sformatf("unexpected frame, kind %0d", m_frame_kind));
            end else begin
                want = pending_frames.pop_front();
                check_field("frame_kind", 32'(want.frame_kind), 32'(m_frame_kind));
                check_field("word0",      32'(want.word0),      32'(m_word0));
                check_field("word1",      32'(want.word1),      32'(m_word1));
                check_field("word2",      32'(want.word2),      32'(m_word2));
                check_field("word3",      32'(want.word3),      32'(m_word3));
                check_field("long_low",   want.long_low,        m_long_low);
                check_field("long_high",  want.long_high,       m_long_high);
                check_field("year",       32'(want.year),       32'(m_year));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence: reset, a directed phase under the reset header, then
    // random phases under the header values 0x00, 0xFF, a random one and the
    // reset value written back.
    // ------------------------------------------------------------------------
    logic [7:0] fixed_payload [8];

    initial begin
        for (int i = 0; i < isfp_pkg::PAYLOAD_LEN; i++)
            payload_mem[i] = 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Bad type bytes just below and just above the type range.
        queue_byte(header_reg, 1'b0);
        queue_byte(isfp_pkg::TYPE_FIRST - 8'd1, 1'b0);
        queue_byte(header_reg, 1'b0);
        queue_byte(isfp_pkg::TYPE_LAST + 8'd1, 1'b0);
        // Time frame with the largest year.
        fixed_payload = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
        queue_frame(isfp_pkg::TYPE_FIRST + 8'(isfp_pkg::KIND_TIME), fixed_payload,
                    1'b0, 1'b0);
        // Position frame with both long words, and word1 and word3, at a signed extreme.
        fixed_payload = '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        queue_frame(isfp_pkg::TYPE_FIRST + 8'(isfp_pkg::KIND_LATLON), fixed_payload,
                    1'b0, 1'b0);

        write_header(8'h00);
        run_random_phase();
        write_header(8'hFF);
        run_random_phase();
        write_header(8'($urandom_range(0, 255)));
        run_random_phase();
        write_header(isfp_pkg::HEADER_RESET);
        run_random_phase();

        while (byte_queue.size() != 0 || s_valid || pending_frames.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_frames.size() != 0)
            flag_error($sformatf("%0d frames never arrived", pending_frames.size()));

        $display("Summary: %0d bytes transferred, %0d decoded frames checked,",
                 bytes_sent, frames_seen);
        $display("  %0d header settings including 0x00 and 0xFF, %0d mismatches.",
                 header_writes, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
